// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LASJ_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lasj assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LASJ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lasj assertion failed");

`endif

// ----- hdl/lasj_pkg.sv -----
`timescale 1ns / 1ps

package lasj_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 64;
    localparam int unsigned COST_BITS_DEF     = 48;

    localparam int unsigned HLEN_W     = 7;
    localparam int unsigned SAVE_W     = 32;
    localparam int unsigned EVAL_W     = 40;
    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVALUATIONS = 2'd2;

    localparam logic [HLEN_W-1:0] HLEN_RESET = 7'd64;
    localparam logic [4:0]        DIV_TEN    = 5'd10;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DIV      = 10'b00_0000_0010,
        S_FILL     = 10'b00_0000_0100,
        S_MOD      = 10'b00_0000_1000,
        S_READ     = 10'b00_0001_0000,
        S_JUDGE    = 10'b00_0010_0000,
        S_UPDATE   = 10'b00_0100_0000,
        S_SCAN     = 10'b00_1000_0000,
        S_SCAN_END = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic fill;
        logic mod_step;
        logic rd_slot;
        logic judge;
        logic update;
        logic scan_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seeded;
        logic div_last;
        logic fill_last;
        logic slot_ok;
        logic rescan;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/lasj_ctrl.sv -----
`timescale 1ns / 1ps

module lasj_ctrl
    import lasj_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cost_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_idle
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cost_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.seeded ? S_MOD : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.slot_ok) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = S_JUDGE;
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.rescan ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ----- hdl/lasj_dp.sv -----
`timescale 1ns / 1ps

module lasj_dp
    import lasj_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int unsigned COST_BITS     = COST_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [COST_BITS-1:0]  i_cost,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_res_stall,
    output logic                  o_res_valid,
    output logic                  o_accepted,
    output logic                  o_new_best,
    output logic [COST_BITS-1:0]  o_current_cost_out,
    output logic [COST_BITS-1:0]  o_threshold_out,
    output logic [EVAL_W-1:0]     o_evaluation_number,
    output logic                  o_autosave_due,
    output logic                  o_finished
);

    localparam int unsigned IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned LW  = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned CW  = (LW > HLEN_W) ? LW : HLEN_W;
    localparam int unsigned SW  = ((LW > IW) ? LW : IW) + 1;

    localparam logic [CW-1:0]        DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [IW-1:0]        LAST_SLOT = IW'(HISTORY_DEPTH - 1);
    localparam logic [COST_BITS-1:0] TEN_C     = COST_BITS'(DIV_TEN);

    // divide-by-ten steps
    localparam logic [3:0] D_HALF  = 4'd0;
    localparam logic [3:0] D_ADD4  = 4'd1;
    localparam logic [3:0] D_ADD8  = 4'd2;
    localparam logic [3:0] D_ADD16 = 4'd3;
    localparam logic [3:0] D_ADD32 = 4'd4;
    localparam logic [3:0] D_SCALE = 4'd5;
    localparam logic [3:0] D_TIMES = 4'd6;
    localparam logic [3:0] D_REM   = 4'd7;
    localparam logic [3:0] D_FIX   = 4'd8;

    // configuration
    logic [HLEN_W-1:0] r_hist_len;
    logic [SAVE_W-1:0] r_save_period;
    logic [EVAL_W-1:0] r_max_eval;

    // search state
    logic [COST_BITS-1:0] r_cur;
    logic [COST_BITS-1:0] r_hmax;
    logic [COST_BITS-1:0] r_best;
    logic [LW-1:0]        r_occ;
    logic [IW-1:0]        r_slot;
    logic                 r_seeded;
    logic [EVAL_W-1:0]    r_evals;
    logic [SAVE_W-1:0]    r_cd;
    logic                 r_scan_v;
    logic                 r_o_valid;

    // per-item working registers
    logic [COST_BITS-1:0] r_cost;
    logic [COST_BITS-1:0] r_div;
    logic [COST_BITS-1:0] r_rem;
    logic [3:0]           r_div_cnt;
    logic [IW-1:0]        r_fill_ptr;
    logic [IW-1:0]        r_l;
    logic [IW-1:0]        r_scan_ptr;
    logic [COST_BITS-1:0] r_prev;
    logic [COST_BITS-1:0] r_rd;
    logic                 r_acc;
    logic                 r_best_hit;
    logic                 r_save;

    logic [COST_BITS-1:0] r_mem [HISTORY_DEPTH];

    // used length
    logic [CW-1:0] w_hl_ext;
    logic [LW-1:0] w_len;
    assign w_hl_ext = CW'(r_hist_len);
    assign w_len    = (r_hist_len == '0)    ? LW'(1) :
                      (w_hl_ext > DEPTH_C)  ? LW'(HISTORY_DEPTH) : LW'(w_hl_ext);

    // seed value: cost + cost/10, saturating
    logic [COST_BITS:0]   w_sum;
    logic [COST_BITS-1:0] w_top;
    assign w_sum = {1'b0, r_cost} + {1'b0, r_div};
    assign w_top = w_sum[COST_BITS] ? '1 : w_sum[COST_BITS-1:0];

    // slot arithmetic
    logic [SW-1:0] w_len_s;
    logic [SW-1:0] w_l_inc;
    logic [SW-1:0] w_scan_inc;
    assign w_len_s    = SW'(w_len);
    assign w_l_inc    = SW'(r_l) + SW'(1);
    assign w_scan_inc = SW'(r_scan_ptr) + SW'(1);

    // history update decision
    logic          w_gt;
    logic          w_lt;
    logic          w_dec;
    logic [LW-1:0] w_occ_n;
    logic          w_rescan;
    assign w_gt     = (r_cur > r_rd);
    assign w_lt     = (r_cur < r_rd) && (r_cur < r_prev);
    assign w_dec    = w_lt && (r_rd == r_hmax) && (r_occ != '0);
    assign w_occ_n  = w_dec ? (r_occ - LW'(1)) : r_occ;
    assign w_rescan = w_lt && (w_occ_n == '0);

    // judge
    logic w_acc;
    assign w_acc = (r_cost == r_cur) || (r_cost < r_hmax);

    // bookkeeping at accept
    logic [SAVE_W:0] w_cd_inc;
    assign w_cd_inc = {1'b0, r_cd} + (SAVE_W + 1)'(1);

    // memory port
    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    logic [COST_BITS-1:0] w_wdata;
    logic                 w_re;
    logic [IW-1:0]        w_raddr;
    assign w_we    = i_cmd.fill || (i_cmd.update && (w_gt || w_lt));
    assign w_waddr = i_cmd.fill ? r_fill_ptr : r_l;
    assign w_wdata = i_cmd.fill ? w_top : r_cur;
    assign w_re    = i_cmd.rd_slot || i_cmd.scan_rd;
    assign w_raddr = i_cmd.rd_slot ? r_l : r_scan_ptr;

    logic w_out_free;
    assign w_out_free = !r_o_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len    <= HLEN_RESET;
            r_save_period <= '0;
            r_max_eval    <= '1;
            r_cur         <= '0;
            r_hmax        <= '0;
            r_best        <= '1;
            r_occ         <= '0;
            r_slot        <= '0;
            r_seeded      <= 1'b0;
            r_evals       <= '0;
            r_cd          <= '0;
            r_scan_v      <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_HISTORY_LENGTH:  r_hist_len    <= i_cfg_data[HLEN_W-1:0];
                    CFG_SAVE_PERIOD:     r_save_period <= i_cfg_data[SAVE_W-1:0];
                    CFG_MAX_EVALUATIONS: r_max_eval    <= i_cfg_data[EVAL_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                if (r_evals != '1) begin
                    r_evals <= r_evals + EVAL_W'(1);
                end
                if (r_save_period == '0) begin
                    r_cd <= '0;
                end else if (w_cd_inc >= {1'b0, r_save_period}) begin
                    r_cd <= '0;
                end else begin
                    r_cd <= w_cd_inc[SAVE_W-1:0];
                end
            end

            if (i_cmd.fill && (r_fill_ptr == LAST_SLOT)) begin
                r_hmax   <= w_top;
                r_cur    <= r_cost;
                r_occ    <= w_len;
                r_seeded <= 1'b1;
            end

            if (i_cmd.judge && w_acc) begin
                r_cur <= r_cost;
                if (r_cost < r_best) begin
                    r_best <= r_cost;
                end
            end

            if (i_cmd.update) begin
                r_slot <= (w_l_inc >= w_len_s) ? '0 : IW'(w_l_inc);
                if (w_rescan) begin
                    r_hmax <= '0;
                    r_occ  <= '0;
                end else begin
                    r_occ <= w_occ_n;
                end
            end

            r_scan_v <= i_cmd.scan_rd;
            if (r_scan_v) begin
                if (r_rd > r_hmax) begin
                    r_hmax <= r_rd;
                    r_occ  <= LW'(1);
                end else if (r_rd == r_hmax) begin
                    r_occ <= r_occ + LW'(1);
                end
            end

            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cost     <= i_cost;
            r_div      <= i_cost;
            r_rem      <= '0;
            r_div_cnt  <= '0;
            r_fill_ptr <= '0;
            r_l        <= r_slot;
            r_save     <= (r_save_period != '0) && (w_cd_inc >= {1'b0, r_save_period});
        end
        // quotient estimate 0.8 * cost / 8 from below, then fix up by the remainder
        if (i_cmd.div_step) begin
            unique case (r_div_cnt)
                D_HALF:  r_div <= (r_cost >> 1) + (r_cost >> 2);
                D_ADD4:  r_div <= r_div + (r_div >> 4);
                D_ADD8:  r_div <= r_div + (r_div >> 8);
                D_ADD16: r_div <= r_div + (r_div >> 16);
                D_ADD32: r_div <= r_div + (r_div >> 32);
                D_SCALE: r_div <= r_div >> 3;
                D_TIMES: r_rem <= (r_div << 3) + (r_div << 1);
                D_REM:   r_rem <= r_cost - r_rem;
                default: begin
                    if (r_rem >= TEN_C) begin
                        r_div <= r_div + COST_BITS'(1);
                        r_rem <= r_rem - TEN_C;
                    end
                end
            endcase
            if (r_div_cnt != D_FIX) begin
                r_div_cnt <= r_div_cnt + 4'd1;
            end
        end
        if (i_cmd.fill) begin
            r_fill_ptr <= r_fill_ptr + IW'(1);
        end
        if (i_cmd.mod_step) begin
            r_l <= IW'(SW'(r_l) - w_len_s);
        end
        if (i_cmd.judge) begin
            r_prev     <= r_cur;
            r_acc      <= w_acc;
            r_best_hit <= w_acc && (r_cost < r_best);
        end
        if (i_cmd.update) begin
            r_scan_ptr <= '0;
        end
        if (i_cmd.scan_rd) begin
            r_scan_ptr <= r_scan_ptr + IW'(1);
        end
        if (i_cmd.out_load) begin
            o_accepted          <= r_acc;
            o_new_best          <= r_best_hit;
            o_current_cost_out  <= r_cur;
            o_threshold_out     <= r_hmax;
            o_evaluation_number <= r_evals;
            o_autosave_due      <= r_save;
            o_finished          <= (r_evals >= r_max_eval);
        end
    end

    assign o_res_valid = r_o_valid;

    assign o_sts.seeded    = r_seeded;
    assign o_sts.div_last  = (r_div_cnt == D_FIX) && (r_rem < TEN_C);
    assign o_sts.fill_last = (r_fill_ptr == LAST_SLOT);
    assign o_sts.slot_ok   = (SW'(r_l) < w_len_s);
    assign o_sts.rescan    = w_rescan;
    assign o_sts.scan_last = (w_scan_inc == w_len_s);
    assign o_sts.out_free  = w_out_free;

endmodule

// ----- hdl/late_acceptance_search_judge_core.sv -----
// Acceptance judge for diversified late acceptance search.
// Input channel: one cost per beat on i_cost_valid / o_cost_stall; a beat is
// taken at a clock edge with valid high and stall low. o_cost_stall is low
// only while the judge is idle, so one item is worked on at a time.
// Result channel: one result beat per input beat on o_res_valid / i_res_stall,
// held in an output register; the next cost is taken while a result waits.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 history length, 1 save period, 2 max evaluations); write only when idle.
// Each item steps through slot check, history read, judge, history update
// and result load; length subtractions come before the read when the slot
// index lies beyond a shortened history, and the history memory is rescanned
// through its single read port when the maximum count runs out.
// The first item after reset also runs a shift-and-add divide by ten
// and fills all HISTORY_DEPTH history slots (one per cycle).
// Reset is synchronous: configuration registers return to defaults, search
// state clears, the history memory keeps garbage until the seeding fill.
// A stalled result holds its beat; the judge waits in its last step until
// the output register frees, stalling input meanwhile.
`timescale 1ns / 1ps

module late_acceptance_search_judge_core
    import lasj_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int unsigned COST_BITS     = COST_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cost_valid,
    output logic                  o_cost_stall,
    input  logic [COST_BITS-1:0]  i_cost,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic                  o_accepted,
    output logic                  o_new_best,
    output logic [COST_BITS-1:0]  o_current_cost_out,
    output logic [COST_BITS-1:0]  o_threshold_out,
    output logic [EVAL_W-1:0]     o_evaluation_number,
    output logic                  o_autosave_due,
    output logic                  o_finished
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_idle;

    lasj_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cost_valid (i_cost_valid),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_idle       (w_idle)
    );

    lasj_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COST_BITS     (COST_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cost              (i_cost),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_res_stall         (i_res_stall),
        .o_res_valid         (o_res_valid),
        .o_accepted          (o_accepted),
        .o_new_best          (o_new_best),
        .o_current_cost_out  (o_current_cost_out),
        .o_threshold_out     (o_threshold_out),
        .o_evaluation_number (o_evaluation_number),
        .o_autosave_due      (o_autosave_due),
        .o_finished          (o_finished)
    );

    assign o_cost_stall = !w_idle;

endmodule

// ----- hdl/lasj_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lasj_checker
    import lasj_pkg::*;
#(
    parameter int unsigned COST_BITS = COST_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cost_valid,
    input logic                 o_cost_stall,
    input logic                 o_res_valid,
    input logic                 i_res_stall,
    input logic                 o_accepted,
    input logic                 o_new_best,
    input logic [COST_BITS-1:0] o_current_cost_out,
    input logic [EVAL_W-1:0]    o_evaluation_number
);

    `LASJ_ASSERT_NEXT(a_res_hold, o_res_valid && i_res_stall, o_res_valid)
    `LASJ_ASSERT_NEXT(a_res_stable, o_res_valid && i_res_stall, $stable(o_current_cost_out) && $stable(o_evaluation_number))
    `LASJ_ASSERT_NEXT(a_busy_after_accept, i_cost_valid && !o_cost_stall, o_cost_stall)
    `LASJ_ASSERT_IMPL(a_best_implies_accept, o_res_valid && o_new_best, o_accepted)
    `LASJ_ASSERT_IMPL(a_count_nonzero, o_res_valid, o_evaluation_number != '0)

endmodule

bind late_acceptance_search_judge_core lasj_checker #(
    .COST_BITS (COST_BITS)
) u_lasj_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_cost_valid        (i_cost_valid),
    .o_cost_stall        (o_cost_stall),
    .o_res_valid         (o_res_valid),
    .i_res_stall         (i_res_stall),
    .o_accepted          (o_accepted),
    .o_new_best          (o_new_best),
    .o_current_cost_out  (o_current_cost_out),
    .o_evaluation_number (o_evaluation_number)
);
